### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion shorthands, sampled on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PPPCA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication
`define PPPCA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### rtl/core/pppca_pkg.sv
// ----------------------------------------------------------------------------
// pppca_pkg
// Types and constants of the PPP control protocol automaton.
// ----------------------------------------------------------------------------
package pppca_pkg;

    localparam int NUM_PROTOCOLS = 5;
    localparam int PROT_IDX_W    = (NUM_PROTOCOLS > 1) ? $clog2(NUM_PROTOCOLS) : 1;

    localparam int CMD_W      = 3;
    localparam int PROT_W     = 3;
    localparam int STATE_W    = 4;
    localparam int CNT_W      = 9;
    localparam int IDENT_W    = 8;
    localparam int MAXC_W     = 8;
    localparam int TICK_W     = 16;
    localparam int DUR_W      = 24;
    localparam int TMR_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [MAXC_W-1:0] CONF_LIMIT_RST    = 8'd10;
    localparam logic [MAXC_W-1:0] TERM_LIMIT_RST    = 8'd2;
    localparam logic [TICK_W-1:0] RESTART_TICKS_RST = 16'd3;

    typedef enum logic [STATE_W-1:0] {
        ST_INITIAL  = 4'd0,
        ST_STARTING = 4'd1,
        ST_CLOSED   = 4'd2,
        ST_STOPPED  = 4'd3,
        ST_CLOSING  = 4'd4,
        ST_STOPPING = 4'd5,
        ST_REQ_SENT = 4'd6,
        ST_ACK_RCVD = 4'd7,
        ST_ACK_SENT = 4'd8,
        ST_OPENED   = 4'd9
    } pppca_state_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_UP      = 3'd0,
        CMD_DOWN    = 3'd1,
        CMD_OPEN    = 3'd2,
        CMD_CLOSE   = 3'd3,
        CMD_TIMEOUT = 3'd4
    } pppca_cmd_t;

    typedef enum logic [TMR_W-1:0] {
        TMR_NONE  = 2'd0,
        TMR_STOP  = 2'd1,
        TMR_START = 2'd2
    } pppca_tmr_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CONF_LIMIT    = 2'd0,
        CFG_TERM_LIMIT    = 2'd1,
        CFG_RESTART_TICKS = 2'd2
    } pppca_cfg_idx_t;

    typedef struct packed {
        logic [MAXC_W-1:0] conf_req_limit;
        logic [MAXC_W-1:0] term_req_limit;
        logic [TICK_W-1:0] restart_ticks;
    } pppca_cfg_t;

    typedef struct packed {
        logic [PROT_W-1:0]  protocol_echo;
        pppca_state_t       new_state;
        logic               layer_started;
        logic               layer_down;
        logic               layer_finished;
        logic               send_config_req;
        logic               send_term_req;
        logic [IDENT_W-1:0] term_ident;
        pppca_tmr_t         timer_action;
        logic [DUR_W-1:0]   timer_duration;
        logic               ignored;
    } pppca_result_t;

    typedef struct packed {
        logic                    we;
        pppca_state_t            state;
        logic signed [CNT_W-1:0] counter;
        logic                    running;
        logic                    ident_inc;
    } pppca_upd_t;

endpackage

### rtl/core/pppca_if.sv
// ----------------------------------------------------------------------------
// pppca_if
// Event and result channels: valid/ready handshake with payload.
// ----------------------------------------------------------------------------
interface pppca_evt_if;
    import pppca_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [PROT_W-1:0] protocol;

    modport source (output valid, command, protocol, input ready);
    modport sink   (input valid, command, protocol, output ready);
endinterface

interface pppca_res_if;
    import pppca_pkg::*;

    logic               valid;
    logic               ready;
    logic [PROT_W-1:0]  protocol_echo;
    logic [STATE_W-1:0] new_state;
    logic               layer_started;
    logic               layer_down;
    logic               layer_finished;
    logic               send_config_req;
    logic               send_term_req;
    logic [IDENT_W-1:0] term_ident;
    logic [TMR_W-1:0]   timer_action;
    logic [DUR_W-1:0]   timer_duration;
    logic               ignored;

    modport source (
        output valid, protocol_echo, new_state, layer_started, layer_down,
               layer_finished, send_config_req, send_term_req, term_ident,
               timer_action, timer_duration, ignored,
        input  ready
    );
    modport sink (
        input  valid, protocol_echo, new_state, layer_started, layer_down,
               layer_finished, send_config_req, send_term_req, term_ident,
               timer_action, timer_duration, ignored,
        output ready
    );
endinterface

### rtl/core/pppca_in_reg.sv
// ----------------------------------------------------------------------------
// pppca_in_reg
// Input register: captures one event per transfer, holds it until taken.
// ----------------------------------------------------------------------------
module pppca_in_reg (
    input  logic                          clk,
    input  logic                          rst_n,
    pppca_evt_if.sink                     evt,
    input  logic                          take,
    output logic                          valid,
    output logic [pppca_pkg::CMD_W-1:0]   command,
    output logic [pppca_pkg::PROT_W-1:0]  protocol
);
    import pppca_pkg::*;

    logic              valid_reg;
    logic [CMD_W-1:0]  command_reg;
    logic [PROT_W-1:0] protocol_reg;

    assign evt.ready = !valid_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (evt.ready)
        begin
            valid_reg <= evt.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt.ready && evt.valid)
        begin
            command_reg  <= evt.command;
            protocol_reg <= evt.protocol;
        end
    end

    assign valid    = valid_reg;
    assign command  = command_reg;
    assign protocol = protocol_reg;
endmodule

### rtl/core/pppca_step.sv
// ----------------------------------------------------------------------------
// pppca_step
// Transition logic: one event against one protocol's state, counter and
// timer bit gives the result and the state update.
// ----------------------------------------------------------------------------
module pppca_step (
    input  logic                                prot_ok,
    input  logic [pppca_pkg::CMD_W-1:0]         command,
    input  logic [pppca_pkg::PROT_W-1:0]        protocol,
    input  pppca_pkg::pppca_state_t             state,
    input  logic signed [pppca_pkg::CNT_W-1:0]  counter,
    input  logic                                running,
    input  logic [pppca_pkg::IDENT_W-1:0]       ident,
    input  pppca_pkg::pppca_cfg_t               cfg,
    output pppca_pkg::pppca_result_t            result,
    output pppca_pkg::pppca_upd_t               upd
);
    import pppca_pkg::*;

    logic signed [CNT_W-1:0] maxc_s;
    logic signed [CNT_W-1:0] maxt_s;
    logic signed [CNT_W-1:0] cnt_dec;
    logic signed [CNT_W-1:0] dur_cnt;
    logic signed [CNT_W:0]   diff;
    logic [CNT_W-1:0]        mult;
    logic [CNT_W+TICK_W-1:0] prod;
    logic                    ent;
    pppca_state_t            ent_st;
    logic                    run_eff;
    logic                    direct_start;
    logic                    do_start;
    logic                    do_stop;

    assign maxc_s  = $signed({1'b0, cfg.conf_req_limit});
    assign maxt_s  = $signed({1'b0, cfg.term_req_limit});
    assign cnt_dec = (counter != -9'sd1) ? counter - 9'sd1 : counter;

    always_comb
    begin
        ent          = 1'b0;
        ent_st       = state;
        run_eff      = running;
        direct_start = 1'b0;
        dur_cnt      = counter;
        upd.counter  = counter;
        upd.running  = running;
        result.layer_started   = 1'b0;
        result.layer_down      = 1'b0;
        result.layer_finished  = 1'b0;
        result.send_config_req = 1'b0;
        result.send_term_req   = 1'b0;

        unique case (pppca_cmd_t'(command))
            CMD_UP:
            begin
                unique case (state)
                    ST_INITIAL:
                    begin
                        ent    = 1'b1;
                        ent_st = ST_CLOSED;
                    end
                    ST_STARTING:
                    begin
                        upd.counter = maxc_s;
                        dur_cnt     = maxc_s;
                        ent         = 1'b1;
                        ent_st      = ST_REQ_SENT;
                        result.send_config_req = 1'b1;
                    end
                    default: ;
                endcase
            end
            CMD_DOWN:
            begin
                unique case (state)
                    ST_CLOSED, ST_CLOSING:
                    begin
                        ent    = 1'b1;
                        ent_st = ST_INITIAL;
                    end
                    ST_STOPPED:
                    begin
                        ent    = 1'b1;
                        ent_st = ST_STARTING;
                        result.layer_started = 1'b1;
                    end
                    ST_STOPPING, ST_REQ_SENT, ST_ACK_RCVD, ST_ACK_SENT:
                    begin
                        ent    = 1'b1;
                        ent_st = ST_STARTING;
                    end
                    ST_OPENED:
                    begin
                        ent    = 1'b1;
                        ent_st = ST_STARTING;
                        result.layer_down = 1'b1;
                    end
                    default: ;
                endcase
            end
            CMD_OPEN:
            begin
                unique case (state)
                    ST_INITIAL:
                    begin
                        ent    = 1'b1;
                        ent_st = ST_STARTING;
                        result.layer_started = 1'b1;
                    end
                    ST_CLOSED:
                    begin
                        upd.counter = maxc_s;
                        dur_cnt     = maxc_s;
                        ent         = 1'b1;
                        ent_st      = ST_REQ_SENT;
                        result.send_config_req = 1'b1;
                    end
                    ST_CLOSING:
                    begin
                        ent    = 1'b1;
                        ent_st = ST_STOPPING;
                    end
                    default: ;
                endcase
            end
            CMD_CLOSE:
            begin
                unique case (state)
                    ST_STARTING:
                    begin
                        ent    = 1'b1;
                        ent_st = ST_INITIAL;
                        result.layer_finished = 1'b1;
                    end
                    ST_STOPPED:
                    begin
                        ent    = 1'b1;
                        ent_st = ST_CLOSED;
                    end
                    ST_STOPPING:
                    begin
                        ent    = 1'b1;
                        ent_st = ST_CLOSING;
                    end
                    ST_OPENED:
                    begin
                        ent         = 1'b1;
                        ent_st      = ST_CLOSING;
                        upd.counter = maxt_s;
                        result.send_term_req = 1'b1;
                        result.layer_down    = 1'b1;
                    end
                    ST_REQ_SENT, ST_ACK_RCVD, ST_ACK_SENT:
                    begin
                        upd.counter = maxt_s;
                        dur_cnt     = maxt_s;
                        ent         = 1'b1;
                        ent_st      = ST_CLOSING;
                        result.send_term_req = 1'b1;
                    end
                    default: ;
                endcase
            end
            CMD_TIMEOUT:
            begin
                run_eff     = 1'b0;
                upd.running = 1'b0;
                upd.counter = cnt_dec;
                dur_cnt     = cnt_dec;
                if (cnt_dec < 0)
                begin
                    unique case (state)
                        ST_CLOSING:
                        begin
                            ent    = 1'b1;
                            ent_st = ST_CLOSED;
                            result.layer_finished = 1'b1;
                        end
                        ST_STOPPING, ST_REQ_SENT, ST_ACK_RCVD, ST_ACK_SENT:
                        begin
                            ent    = 1'b1;
                            ent_st = ST_STOPPED;
                            result.layer_finished = 1'b1;
                        end
                        default: ;
                    endcase
                end
                else
                begin
                    unique case (state)
                        ST_CLOSING, ST_STOPPING:
                        begin
                            direct_start = 1'b1;
                            result.send_term_req = 1'b1;
                        end
                        ST_REQ_SENT, ST_ACK_RCVD:
                        begin
                            ent    = 1'b1;
                            ent_st = ST_REQ_SENT;
                            result.send_config_req = 1'b1;
                        end
                        ST_ACK_SENT:
                        begin
                            direct_start = 1'b1;
                            result.send_config_req = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase

        do_stop  = ent && (ent_st == ST_INITIAL || ent_st == ST_STARTING ||
                           ent_st == ST_CLOSED || ent_st == ST_STOPPED ||
                           ent_st == ST_OPENED);
        do_start = direct_start || (ent && !do_stop && !run_eff);

        if (do_stop)
        begin
            upd.running = 1'b0;
        end
        else if (do_start)
        begin
            upd.running = 1'b1;
        end

        diff = $signed({2'b00, cfg.conf_req_limit}) - $signed({dur_cnt[CNT_W-1], dur_cnt});
        mult = (diff < 10'sd1) ? 9'd1 : diff[CNT_W-1:0];
        prod = mult * cfg.restart_ticks;

        result.protocol_echo = protocol;
        result.new_state     = ent ? ent_st : state;
        result.term_ident    = result.send_term_req ? ident + 8'd1 : '0;
        if (do_stop)
        begin
            result.timer_action   = TMR_STOP;
            result.timer_duration = '0;
        end
        else if (do_start)
        begin
            result.timer_action   = TMR_START;
            result.timer_duration = prod[DUR_W-1:0];
        end
        else
        begin
            result.timer_action   = TMR_NONE;
            result.timer_duration = '0;
        end
        result.ignored = !ent && !result.layer_started && !result.layer_down &&
                         !result.layer_finished && !result.send_config_req &&
                         !result.send_term_req && (result.timer_action == TMR_NONE);

        upd.we        = prot_ok;
        upd.state     = result.new_state;
        upd.ident_inc = result.send_term_req;

        if (!prot_ok)
        begin
            result.new_state       = ST_INITIAL;
            result.layer_started   = 1'b0;
            result.layer_down      = 1'b0;
            result.layer_finished  = 1'b0;
            result.send_config_req = 1'b0;
            result.send_term_req   = 1'b0;
            result.term_ident      = '0;
            result.timer_action    = TMR_NONE;
            result.timer_duration  = '0;
            result.ignored         = 1'b1;
            upd.ident_inc          = 1'b0;
        end
    end
endmodule

### rtl/core/ppp_control_protocol_automaton.sv
// ----------------------------------------------------------------------------
// ppp_control_protocol_automaton
// An event passes the input register, then the result register, to the result.
// Throughput: one event per cycle while res.ready holds no result back,
// also back to back on the same protocol.
// Reset: all protocols initial, counters and timer bits clear, identifier 0,
// restart limits 10 and 2, restart ticks 3.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ppp_control_protocol_automaton (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [pppca_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pppca_pkg::CFG_DATA_W-1:0]   cfg_data,
    pppca_evt_if.sink                          evt,
    pppca_res_if.source                        res
);
    import pppca_pkg::*;

    pppca_cfg_t              cfg_reg;
    pppca_state_t            st_reg  [NUM_PROTOCOLS];
    logic signed [CNT_W-1:0] cnt_reg [NUM_PROTOCOLS];
    logic                    run_reg [NUM_PROTOCOLS];
    logic [IDENT_W-1:0]      ident_reg;
    pppca_result_t           res_reg;
    logic                    out_valid_reg;

    logic                    in_valid;
    logic [CMD_W-1:0]        in_command;
    logic [PROT_W-1:0]       in_protocol;
    logic [PROT_IDX_W-1:0]   p_idx;
    logic                    prot_ok;
    logic                    adv;
    pppca_result_t           result;
    pppca_upd_t              upd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.conf_req_limit <= CONF_LIMIT_RST;
            cfg_reg.term_req_limit <= TERM_LIMIT_RST;
            cfg_reg.restart_ticks  <= RESTART_TICKS_RST;
        end
        else if (cfg_we)
        begin
            unique case (pppca_cfg_idx_t'(cfg_index))
                CFG_CONF_LIMIT:    cfg_reg.conf_req_limit <= cfg_data[MAXC_W-1:0];
                CFG_TERM_LIMIT:    cfg_reg.term_req_limit <= cfg_data[MAXC_W-1:0];
                CFG_RESTART_TICKS: cfg_reg.restart_ticks  <= cfg_data[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    pppca_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .evt      (evt),
        .take     (adv),
        .valid    (in_valid),
        .command  (in_command),
        .protocol (in_protocol)
    );

    assign adv     = in_valid && (!out_valid_reg || res.ready);
    assign prot_ok = int'(in_protocol) < NUM_PROTOCOLS;
    assign p_idx   = prot_ok ? PROT_IDX_W'(in_protocol) : '0;

    pppca_step u_step (
        .prot_ok  (prot_ok),
        .command  (in_command),
        .protocol (in_protocol),
        .state    (st_reg[p_idx]),
        .counter  (cnt_reg[p_idx]),
        .running  (run_reg[p_idx]),
        .ident    (ident_reg),
        .cfg      (cfg_reg),
        .result   (result),
        .upd      (upd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PROTOCOLS; i++)
            begin
                st_reg[i]  <= ST_INITIAL;
                cnt_reg[i] <= '0;
                run_reg[i] <= 1'b0;
            end
            ident_reg <= '0;
        end
        else if (adv)
        begin
            if (upd.we)
            begin
                st_reg[p_idx]  <= upd.state;
                cnt_reg[p_idx] <= upd.counter;
                run_reg[p_idx] <= upd.running;
            end
            if (upd.ident_inc)
            begin
                ident_reg <= ident_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg <= result;
        end
    end

    assign res.valid           = out_valid_reg;
    assign res.protocol_echo   = res_reg.protocol_echo;
    assign res.new_state       = STATE_W'(res_reg.new_state);
    assign res.layer_started   = res_reg.layer_started;
    assign res.layer_down      = res_reg.layer_down;
    assign res.layer_finished  = res_reg.layer_finished;
    assign res.send_config_req = res_reg.send_config_req;
    assign res.send_term_req   = res_reg.send_term_req;
    assign res.term_ident      = res_reg.term_ident;
    assign res.timer_action    = TMR_W'(res_reg.timer_action);
    assign res.timer_duration  = res_reg.timer_duration;
    assign res.ignored         = res_reg.ignored;

    `PPPCA_ASSERT_NEXT(a_held_event, in_valid && !adv, in_valid && $stable(in_command) && $stable(in_protocol))
    `PPPCA_ASSERT_NEXT(a_start_sets_run, adv && upd.we && result.timer_action == TMR_START, run_reg[$past(p_idx)])
    `PPPCA_ASSERT_NEXT(a_ident_step, adv && result.send_term_req, ident_reg == $past(ident_reg) + 8'd1)
    `PPPCA_ASSERT_NOW(a_bad_prot_quiet, adv && !prot_ok, result.ignored && !upd.ident_inc)

endmodule
